[design/plss_pkg.sv]
// Package for the parallel LED strip serializer.
// Holds command codes, register indexes, reset values and the shared structs.
// No dependencies.
package plss_pkg;

    localparam int OUT_LANES      = 16;
    localparam int COLOR_W        = 24;
    localparam int BITS_PER_PIXEL = 24;
    localparam int SLOT_W         = 13;
    localparam int PIXC_W         = 9;
    localparam int NPIX_W         = 11;
    localparam int FSLOT_W        = 16;
    localparam int BIT_W          = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_SEND  = 2'd3
    } t_command;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_TICK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TICK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TICKS   = 3'd4;

    localparam logic [8:0]  RST_PIXELS_IN_USE = 9'd256;
    localparam logic [7:0]  RST_SLOT_TICKS    = 8'd30;
    localparam logic [7:0]  RST_DATA_TICK     = 8'd9;
    localparam logic [7:0]  RST_LOW_TICK      = 8'd21;
    localparam logic [15:0] RST_RESET_TICKS   = 16'd1500;

    typedef struct packed {
        t_command   command;
        logic [3:0] lane;
        logic [7:0] pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_item;

    typedef struct packed {
        logic [OUT_LANES-1:0] lane_levels;
        logic                 busy_res;
        logic                 rejected;
        logic                 frame_done;
    } t_result;

    typedef struct packed {
        logic load;
        logic commit;
        logic clr_run;
    } t_dp_cmd;

    typedef struct packed {
        logic item_clear;
        logic clr_last;
    } t_dp_status;

endpackage

[design/plss_in_if.sv]
// Input channel of the LED strip serializer: one command item per handshake.
// Depends on plss_pkg.
interface plss_in_if;
    import plss_pkg::*;

    logic       valid;
    logic       ready;
    t_command   command;
    logic [3:0] lane;
    logic [7:0] pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, command, lane, pixel, red, green, blue, input ready);
    modport sink   (input valid, command, lane, pixel, red, green, blue, output ready);
endinterface

[design/plss_out_if.sv]
// Result channel of the LED strip serializer: one result item per command.
// Depends on plss_pkg.
interface plss_out_if;
    import plss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_LANES-1:0] lane_levels;
    logic                 busy_res;
    logic                 rejected;
    logic                 frame_done;

    modport source (output valid, lane_levels, busy_res, rejected, frame_done, input ready);
    modport sink   (input valid, lane_levels, busy_res, rejected, frame_done, output ready);
endinterface

[design/plss_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module plss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/plss_ctrl.sv]
// Controller of the LED strip serializer: item sequencing, store clearing
// passes and the result valid flag. Depends on plss_pkg.
module plss_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output plss_pkg::t_dp_cmd    o_cmd,
    input  plss_pkg::t_dp_status i_status
);
    import plss_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load    = o_in_ready && i_in_valid;
        o_cmd.clr_run = (r_state == S_INIT) || (r_state == S_CLEAR);
        o_cmd.commit  = out_free &&
                        (((r_state == S_EXEC) && !i_status.item_clear) ||
                         ((r_state == S_CLEAR) && i_status.clr_last));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end
            unique case (r_state)
                S_INIT: begin
                    if (i_status.clr_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_cmd.load) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (out_free) r_state <= i_status.item_clear ? S_CLEAR : S_IDLE;
                end
                S_CLEAR: begin
                    if (o_cmd.commit) r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("result not flagged valid after commit");
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_in_ready)
        else $error("item taken while previous item in work");
    a_clear_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && !i_status.clr_last) |=> (r_state == S_CLEAR))
        else $error("clear pass left early");
`endif
endmodule

[design/plss_datapath.sv]
// Datapath of the LED strip serializer: registers, pixel stores per lane,
// frame counters and result register. Depends on plss_pkg and plss_ram.
module plss_datapath #(
    parameter int LANES      = 16,
    parameter int MAX_PIXELS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  plss_pkg::t_dp_cmd                  i_cmd,
    output plss_pkg::t_dp_status               o_status,
    input  plss_pkg::t_item                    i_item,
    input  logic                               i_cfg_we,
    input  logic [plss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [plss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output plss_pkg::t_result                  o_res
);
    import plss_pkg::*;

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [8:0]  r_pixels_in_use;
    logic [7:0]  r_slot_ticks;
    logic [7:0]  r_data_tick;
    logic [7:0]  r_low_tick;
    logic [15:0] r_reset_ticks;

    t_item   r_item;
    t_result r_res, n_res;

    logic              r_sending, n_sending;
    logic              r_latching, n_latching;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [PIXC_W-1:0] r_pixc, n_pixc;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [7:0]        r_tick, n_tick;
    logic [15:0]       r_latch, n_latch;
    logic [ADDR_W-1:0] r_clr_addr;

    logic                busy;
    logic [NPIX_W-1:0]   pix_ext;
    logic [NPIX_W-1:0]   npix;
    logic [FSLOT_W-1:0]  frame_slots;
    logic                pre_end;
    logic                send_eff;
    logic [15:0]         lat_sum;
    logic [BIT_W-1:0]    bit_sel;
    logic [LANES-1:0]    lane_data;
    logic [OUT_LANES+LANES-1:0] data_ext;
    logic [OUT_LANES+LANES-1:0] ones_ext;
    logic                wr_ok;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ADDR_W+PIXC_W-1:0] pixc_ext;
    logic [ADDR_W+7:0]   wpix_ext;
    logic [COLOR_W-1:0]  ram_wdata;
    logic [COLOR_W-1:0]  rdata [LANES];
    logic                clr_last;

    assign busy = r_sending || r_latching;

    // frame length clamped to 1..MAX_PIXELS, slots = n * 24
    always_comb begin
        pix_ext = {2'b00, r_pixels_in_use};
        if (pix_ext == '0) begin
            npix = NPIX_W'(1);
        end else if (pix_ext > NPIX_W'(MAX_PIXELS)) begin
            npix = NPIX_W'(MAX_PIXELS);
        end else begin
            npix = pix_ext;
        end
        frame_slots = ({5'b0, npix} << 4) + ({5'b0, npix} << 3);
    end

    assign pre_end  = r_sending && ({3'b000, r_slot} >= frame_slots);
    assign send_eff = r_sending && !pre_end;
    assign lat_sum  = (pre_end ? 16'd0 : r_latch) + 16'd1;
    assign bit_sel  = BIT_W'(BITS_PER_PIXEL - 1) - r_bit;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic lane_we;
        assign lane_we = i_cmd.clr_run ||
                         (wr_ok && ({1'b0, r_item.lane} == 5'(l)));
        assign lane_data[l] = rdata[l][bit_sel];

        plss_ram #(
            .WIDTH (COLOR_W),
            .DEPTH (MAX_PIXELS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (lane_we),
            .i_addr  (ram_addr),
            .i_wdata (ram_wdata),
            .o_rdata (rdata[l])
        );
    end

    assign data_ext = {{OUT_LANES{1'b0}}, lane_data};
    assign ones_ext = {{OUT_LANES{1'b0}}, {LANES{1'b1}}};

    assign wr_ok = i_cmd.commit && (r_item.command == CMD_WRITE) && !busy &&
                   ({1'b0, r_item.lane} < 5'(LANES)) &&
                   ({3'b000, r_item.pixel} < NPIX_W'(MAX_PIXELS));

    assign pixc_ext = {{ADDR_W{1'b0}}, r_pixc};
    assign wpix_ext = {{ADDR_W{1'b0}}, r_item.pixel};

    always_comb begin
        if (i_cmd.clr_run) begin
            ram_addr  = r_clr_addr;
            ram_wdata = '0;
        end else if (wr_ok) begin
            ram_addr  = wpix_ext[ADDR_W-1:0];
            ram_wdata = {r_item.green, r_item.red, r_item.blue};
        end else begin
            ram_addr  = pixc_ext[ADDR_W-1:0];
            ram_wdata = {r_item.green, r_item.red, r_item.blue};
        end
    end

    assign clr_last = (r_clr_addr == ADDR_W'(MAX_PIXELS - 1));

    always_comb begin
        o_status.item_clear = (r_item.command == CMD_CLEAR) && !busy;
        o_status.clr_last   = clr_last;
    end

    always_comb begin
        n_sending  = r_sending;
        n_latching = r_latching;
        n_slot     = r_slot;
        n_pixc     = r_pixc;
        n_bit      = r_bit;
        n_tick     = r_tick;
        n_latch    = r_latch;
        n_res      = '0;
        unique case (r_item.command)
            CMD_TICK: begin
                if (pre_end) begin
                    n_sending  = 1'b0;
                    n_latching = 1'b1;
                    n_latch    = '0;
                end
                if (send_eff) begin
                    if (r_tick < r_data_tick) begin
                        n_res.lane_levels = ones_ext[OUT_LANES-1:0];
                    end else if (r_tick < r_low_tick) begin
                        n_res.lane_levels = data_ext[OUT_LANES-1:0];
                    end
                    if (({1'b0, r_tick} + 9'd1) >= {1'b0, r_slot_ticks}) begin
                        n_tick = '0;
                        n_slot = r_slot + SLOT_W'(1);
                        if (r_slot == '1) begin
                            n_pixc = '0;
                            n_bit  = '0;
                        end else if (r_bit == BIT_W'(BITS_PER_PIXEL - 1)) begin
                            n_bit  = '0;
                            n_pixc = r_pixc + PIXC_W'(1);
                        end else begin
                            n_bit = r_bit + BIT_W'(1);
                        end
                        if ({3'b000, n_slot} >= frame_slots) begin
                            n_sending  = 1'b0;
                            n_latching = 1'b1;
                            n_latch    = '0;
                        end
                    end else begin
                        n_tick = r_tick + 8'd1;
                    end
                end else if (r_latching || pre_end) begin
                    if ((lat_sum >= r_reset_ticks) || (lat_sum == '0)) begin
                        n_latching       = 1'b0;
                        n_latch          = '0;
                        n_res.frame_done = 1'b1;
                    end else begin
                        n_latch = lat_sum;
                    end
                end
            end
            CMD_WRITE, CMD_CLEAR: begin
                n_res.rejected = busy;
            end
            CMD_SEND: begin
                if (busy) begin
                    n_res.rejected = 1'b1;
                end else begin
                    n_sending  = 1'b1;
                    n_latching = 1'b0;
                    n_slot     = '0;
                    n_pixc     = '0;
                    n_bit      = '0;
                    n_tick     = '0;
                    n_latch    = '0;
                end
            end
        endcase
        n_res.busy_res = n_sending || n_latching;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixels_in_use <= RST_PIXELS_IN_USE;
            r_slot_ticks    <= RST_SLOT_TICKS;
            r_data_tick     <= RST_DATA_TICK;
            r_low_tick      <= RST_LOW_TICK;
            r_reset_ticks   <= RST_RESET_TICKS;
            r_sending       <= 1'b0;
            r_latching      <= 1'b0;
            r_slot          <= '0;
            r_pixc          <= '0;
            r_bit           <= '0;
            r_tick          <= '0;
            r_latch         <= '0;
            r_clr_addr      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PIXELS_IN_USE: r_pixels_in_use <= i_cfg_data[8:0];
                    CFG_SLOT_TICKS:    r_slot_ticks    <= i_cfg_data[7:0];
                    CFG_DATA_TICK:     r_data_tick     <= i_cfg_data[7:0];
                    CFG_LOW_TICK:      r_low_tick      <= i_cfg_data[7:0];
                    CFG_RESET_TICKS:   r_reset_ticks   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_sending  <= n_sending;
                r_latching <= n_latching;
                r_slot     <= n_slot;
                r_pixc     <= n_pixc;
                r_bit      <= n_bit;
                r_tick     <= n_tick;
                r_latch    <= n_latch;
            end
            if (i_cmd.load) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_run && !clr_last) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.commit) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

`ifndef SYNTHESIS
    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sending && r_latching))
        else $error("sending and latching at once");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit < BIT_W'(BITS_PER_PIXEL))
        else $error("bit counter out of range");
    a_send_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_item.command == CMD_SEND) && !busy) |=>
        (r_sending && (r_slot == '0) && (r_tick == '0)))
        else $error("send did not start a frame");
`endif
endmodule

[design/parallel_led_strip_serializer.sv]
// Parallel LED strip serializer: one command item in, one result item out.
// An item is taken in the idle state only; its result is registered once the
// result register is free, and no further item is taken before that commit.
// A clear item sweeps the per-lane stores one row a cycle when no frame is out.
// Reset: config and frame registers take their defaults, then a clearing pass
// zeroes the stores while no item is taken; config writes still land.
module parallel_led_strip_serializer #(
    parameter int LANES      = 16,
    parameter int MAX_PIXELS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    plss_in_if.sink                         i_item,
    plss_out_if.source                      o_result,
    input  logic                            i_cfg_we,
    input  logic [plss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [plss_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import plss_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_item      item;
    t_result    res;
    logic       out_valid;
    logic       in_ready;

    always_comb begin
        item.command = i_item.command;
        item.lane    = i_item.lane;
        item.pixel   = i_item.pixel;
        item.red     = i_item.red;
        item.green   = i_item.green;
        item.blue    = i_item.blue;
    end

    plss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    plss_datapath #(
        .LANES      (LANES),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_item      (item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (res)
    );

    assign i_item.ready         = in_ready;
    assign o_result.valid       = out_valid;
    assign o_result.lane_levels = res.lane_levels;
    assign o_result.busy_res    = res.busy_res;
    assign o_result.rejected    = res.rejected;
    assign o_result.frame_done  = res.frame_done;
endmodule

[tb/parallel_led_strip_serializer_test.sv]
// Self-checking testbench for parallel_led_strip_serializer.
// Predicts every result item from its own model of the pixel store and the frame timing.
// Depends on plss_pkg, plss_in_if, plss_out_if and the serializer RTL.
`timescale 1ns / 1ps

module parallel_led_strip_serializer_test;
    import plss_pkg::*;

    localparam int          MAX_PIXELS   = 256;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_LIMIT  = 4000;
    localparam int unsigned RANDOM_ITEMS = 150;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    plss_in_if  in_ch ();
    plss_out_if out_ch ();

    parallel_led_strip_serializer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (in_ch),
        .o_result    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // model of the strip store, frame state and registers
    logic [COLOR_W-1:0] strip_colors [OUT_LANES][MAX_PIXELS];
    bit                 m_sending;
    bit                 m_latching;
    logic [12:0]        m_slot;
    logic [7:0]         m_tick;
    logic [15:0]        m_latch;
    logic [8:0]         r_pixels;
    logic [7:0]         r_slot_ticks;
    logic [7:0]         r_data_tick;
    logic [7:0]         r_low_tick;
    logic [15:0]        r_reset_ticks;

    t_result     strip_results_due [$];
    int          errors = 0;
    int unsigned items_sent = 0;
    bit          src_gaps = 1'b1;
    bit          rcv_gaps = 1'b1;
    int          hold_orders = 0;

    function automatic void wipe_colors();
        foreach (strip_colors[l, p]) strip_colors[l][p] = '0;
    endfunction

    function automatic void reset_strip_model();
        wipe_colors();
        m_sending     = 1'b0;
        m_latching    = 1'b0;
        m_slot        = '0;
        m_tick        = '0;
        m_latch       = '0;
        r_pixels      = RST_PIXELS_IN_USE;
        r_slot_ticks  = RST_SLOT_TICKS;
        r_data_tick   = RST_DATA_TICK;
        r_low_tick    = RST_LOW_TICK;
        r_reset_ticks = RST_RESET_TICKS;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PIXELS_IN_USE: r_pixels      = data[8:0];
            CFG_SLOT_TICKS:    r_slot_ticks  = data[7:0];
            CFG_DATA_TICK:     r_data_tick   = data[7:0];
            CFG_LOW_TICK:      r_low_tick    = data[7:0];
            CFG_RESET_TICKS:   r_reset_ticks = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic int unsigned frame_slot_count();
        int unsigned n;
        n = r_pixels;
        if (n < 1) n = 1;
        if (n > MAX_PIXELS) n = MAX_PIXELS;
        return n * BITS_PER_PIXEL;
    endfunction

    function automatic logic [OUT_LANES-1:0] slot_data_levels();
        int unsigned          pix;
        int unsigned          shift;
        logic [OUT_LANES-1:0] lv;
        pix   = m_slot / BITS_PER_PIXEL;
        shift = BITS_PER_PIXEL - 1 - (m_slot % BITS_PER_PIXEL);
        lv    = '0;
        if (pix < MAX_PIXELS) begin
            for (int l = 0; l < OUT_LANES; l++) lv[l] = strip_colors[l][pix][shift];
        end
        return lv;
    endfunction

    function automatic void enter_latch();
        m_sending  = 1'b0;
        m_latching = 1'b1;
        m_latch    = '0;
    endfunction

    function automatic t_result predict_strip_step(t_item it);
        t_result r;
        bit      was_busy;
        r        = '0;
        was_busy = m_sending || m_latching;
        if (it.command == CMD_TICK) begin
            if (m_sending && m_slot >= frame_slot_count()) enter_latch();
            if (m_sending) begin
                if (m_tick < r_data_tick) r.lane_levels = '1;
                else if (m_tick < r_low_tick) r.lane_levels = slot_data_levels();
                if (int'(m_tick) + 1 >= int'(r_slot_ticks)) begin
                    m_tick = '0;
                    m_slot = m_slot + 13'd1;
                    if (m_slot >= frame_slot_count()) enter_latch();
                end else begin
                    m_tick = m_tick + 8'd1;
                end
            end else if (m_latching) begin
                m_latch = m_latch + 16'd1;
                if (m_latch >= r_reset_ticks || m_latch == 16'd0) begin
                    m_latching   = 1'b0;
                    m_latch      = '0;
                    r.frame_done = 1'b1;
                end
            end
        end else if (was_busy) begin
            r.rejected = 1'b1;
        end else begin
            case (it.command)
                CMD_WRITE: strip_colors[it.lane][it.pixel] = {it.green, it.red, it.blue};
                CMD_CLEAR: wipe_colors();
                CMD_SEND: begin
                    m_sending  = 1'b1;
                    m_latching = 1'b0;
                    m_slot     = '0;
                    m_tick     = '0;
                    m_latch    = '0;
                end
                default: ;
            endcase
        end
        r.busy_res = m_sending || m_latching;
        return r;
    endfunction

    function automatic t_item rand_item(t_command cmd);
        t_item it;
        it.command = cmd;
        it.lane    = 4'($urandom);
        it.pixel   = 8'($urandom);
        it.red     = 8'($urandom);
        it.green   = 8'($urandom);
        it.blue    = 8'($urandom);
        return it;
    endfunction

    function automatic t_item color_write(logic [3:0] lane, logic [7:0] pixel,
                                          logic [7:0] g, logic [7:0] r, logic [7:0] b);
        t_item it;
        it.command = CMD_WRITE;
        it.lane    = lane;
        it.pixel   = pixel;
        it.green   = g;
        it.red     = r;
        it.blue    = b;
        return it;
    endfunction

    function automatic void flag_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            if (errors < 200)
                $display("%0t: %s expected %h actual %h", $time, field, want, got);
            errors++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (strip_results_due.size() == 0) begin
                if (errors < 200)
                    $display("%0t: result with none expected, actual levels %h busy %b",
                             $time, out_ch.lane_levels, out_ch.busy_res);
                errors++;
            end else begin
                want = strip_results_due.pop_front();
                flag_field("lane_levels", want.lane_levels, out_ch.lane_levels);
                flag_field("busy_res", want.busy_res, out_ch.busy_res);
                flag_field("rejected", want.rejected, out_ch.rejected);
                flag_field("frame_done", want.frame_done, out_ch.frame_done);
            end
        end
    end

    // result receiver with random stalls and long hold-offs on request
    initial begin : result_sink
        int stall_left;
        int orders_seen;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        orders_seen  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_orders != orders_seen) begin
                orders_seen = hold_orders;
                stall_left  = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (rcv_gaps) begin
                out_ch.ready <= ($urandom_range(99) >= 30);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input t_item it);
        @(negedge i_clk);
        if (src_gaps && $urandom_range(99) < 30) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= it.command;
        in_ch.lane    <= it.lane;
        in_ch.pixel   <= it.pixel;
        in_ch.red     <= it.red;
        in_ch.green   <= it.green;
        in_ch.blue    <= it.blue;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        strip_results_due.push_back(predict_strip_step(it));
        items_sent++;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (strip_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (strip_results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, strip_results_due.size());
            errors++;
            strip_results_due.delete();
        end
    endtask

    // a clear has swept the whole store by the time its result is flagged
    task automatic settle();
        drain_results();
        repeat (MAX_PIXELS + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input int unsigned pixels, slot, dtick, ltick, rticks);
        settle();
        write_reg(CFG_PIXELS_IN_USE, CFG_DATA_W'(pixels));
        write_reg(CFG_SLOT_TICKS, CFG_DATA_W'(slot));
        write_reg(CFG_DATA_TICK, CFG_DATA_W'(dtick));
        write_reg(CFG_LOW_TICK, CFG_DATA_W'(ltick));
        write_reg(CFG_RESET_TICKS, CFG_DATA_W'(rticks));
    endtask

    task automatic finish_frame();
        while (m_sending || m_latching) send_item(rand_item(CMD_TICK));
    endtask

    task automatic frame_once(input int unsigned pixels, slot, dtick, ltick, rticks);
        set_timing(pixels, slot, dtick, ltick, rticks);
        send_item(color_write(4'($urandom), 8'd0, 8'($urandom), 8'($urandom), 8'($urandom)));
        send_item(rand_item(CMD_SEND));
        finish_frame();
    endtask

    task automatic test_reset_state();
        repeat (2) send_item(rand_item(CMD_TICK));
        send_item(color_write(4'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF));
        send_item(color_write(4'd15, 8'd255, 8'h80, 8'h01, 8'h7F));
        send_item(color_write(4'd15, 8'd0, 8'hA5, 8'h5A, 8'hC3));
        send_item(rand_item(CMD_CLEAR));
        send_item(color_write(4'd3, 8'd1, 8'h12, 8'h34, 8'h56));
        send_item(rand_item(CMD_TICK));
    endtask

    task automatic test_basic_frame();
        set_timing(2, 3, 1, 2, 3);
        send_item(color_write(4'd0, 8'd0, 8'hAA, 8'h55, 8'hF0));
        send_item(color_write(4'd15, 8'd1, 8'hFF, 8'h00, 8'h81));
        send_item(color_write(4'd7, 8'd0, 8'h0F, 8'hC3, 8'h3C));
        send_item(rand_item(CMD_SEND));
        send_item(rand_item(CMD_WRITE));
        send_item(rand_item(CMD_CLEAR));
        send_item(rand_item(CMD_SEND));
        while (m_sending) send_item(rand_item(CMD_TICK));
        send_item(rand_item(CMD_WRITE));
        send_item(rand_item(CMD_SEND));
        finish_frame();
        repeat (2) send_item(rand_item(CMD_TICK));
    endtask

    // zero pixels clamps to one, zero latch acts as one
    task automatic test_short_slots();
        frame_once(0, 0, 0, 1, 0);
        frame_once(0, 1, 1, 255, 0);
    endtask

    task automatic test_crossed_ticks();
        frame_once(1, 3, 2, 1, 1);
        frame_once(1, 2, 254, 2, 1);
    endtask

    task automatic test_shrink_during_frame();
        set_timing(3, 2, 1, 2, 2);
        send_item(rand_item(CMD_SEND));
        repeat (52) send_item(rand_item(CMD_TICK));
        settle();
        write_reg(CFG_PIXELS_IN_USE, CFG_DATA_W'(1));
        finish_frame();
        set_timing(1, 3, 1, 2, 3);
        send_item(rand_item(CMD_SEND));
        repeat (10) send_item(rand_item(CMD_TICK));
        settle();
        write_reg(CFG_SLOT_TICKS, CFG_DATA_W'(2));
        write_reg(CFG_DATA_TICK, CFG_DATA_W'(0));
        write_reg(CFG_LOW_TICK, CFG_DATA_W'(1));
        finish_frame();
    endtask

    task automatic test_back_pressure();
        set_timing(1, 3, 1, 2, 4);
        send_item(rand_item(CMD_SEND));
        src_gaps = 1'b0;
        hold_orders++;
        repeat (40) send_item(rand_item(CMD_TICK));
        drain_results();
        finish_frame();
        src_gaps = 1'b1;
    endtask

    // length above MAX_PIXELS clamps; cut short once two pixels went out
    task automatic test_clamped_length();
        set_timing(511, 1, 0, 1, 2);
        send_item(color_write(4'd0, 8'd0, 8'hC3, 8'h96, 8'h69));
        send_item(color_write(4'd15, 8'd1, 8'hFF, 8'h0F, 8'hF0));
        send_item(color_write(4'd9, 8'd1, 8'h01, 8'h80, 8'hFF));
        send_item(rand_item(CMD_SEND));
        repeat (48) send_item(rand_item(CMD_TICK));
        settle();
        write_reg(CFG_PIXELS_IN_USE, CFG_DATA_W'(2));
        finish_frame();
    endtask

    task automatic test_long_latch();
        src_gaps = 1'b0;
        rcv_gaps = 1'b0;
        frame_once(1, 1, 0, 1, 40);
        src_gaps = 1'b1;
        rcv_gaps = 1'b1;
    endtask

    task automatic test_random_frames();
        int unsigned first;
        t_item       it;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            src_gaps = ($urandom_range(3) != 0);
            rcv_gaps = ($urandom_range(3) != 0);
            set_timing($urandom_range(2), $urandom_range(4), $urandom_range(5),
                       $urandom_range(5), $urandom_range(12));
            if ($urandom_range(5) == 0) send_item(rand_item(CMD_CLEAR));
            repeat ($urandom_range(8, 2)) begin
                it = rand_item(CMD_WRITE);
                if ($urandom_range(3) != 0) it.pixel = 8'($urandom_range(2));
                send_item(it);
            end
            repeat ($urandom_range(3)) send_item(rand_item(CMD_TICK));
            send_item(rand_item(CMD_SEND));
            while (m_sending || m_latching)
                send_item(rand_item($urandom_range(99) < 12 ?
                                    t_command'($urandom_range(3, 1)) : CMD_TICK));
            repeat ($urandom_range(4)) send_item(rand_item(t_command'($urandom_range(2))));
        end
        src_gaps = 1'b1;
        rcv_gaps = 1'b1;
    endtask

    initial begin
        reset_strip_model();
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_TICK;
        in_ch.lane    = '0;
        in_ch.pixel   = '0;
        in_ch.red     = '0;
        in_ch.green   = '0;
        in_ch.blue    = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_PIXELS_IN_USE;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_basic_frame();
        test_short_slots();
        test_crossed_ticks();
        test_shrink_during_frame();
        test_back_pressure();
        test_clamped_length();
        test_long_latch();
        test_random_frames();

        drain_results();
        repeat (MAX_PIXELS + 16) @(posedge i_clk);
        if (errors == 0) begin
            $display("[parallel_led_strip_serializer] OK");
        end else begin
            $display("[parallel_led_strip_serializer] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[parallel_led_strip_serializer] ERROR");
        $finish;
    end

endmodule
